### hw/rtl/sbg_pkg.sv
// Shared types, widths and saturation helper for the softmax backward gradient block.
package sbg_pkg;

   localparam int DATA_W = 16;
   localparam int ACC_W  = 48;
   localparam int TERM_W = 33;
   localparam int PROD_W = 34;
   localparam int FRAC_W = 15;

   typedef struct packed {
      logic store;
      logic dot_load;
      logic rd;
      logic mul;
      logic advance;
      logic clear;
   } sbg_cmd_type;

   typedef struct packed {
      logic last_elem;
   } sbg_sts_type;

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic signed [DATA_W-1:0] r;
      hi = ACC_W'(32767);
      lo = -ACC_W'(32768);
      if (v > hi) begin
         r = 16'sh7fff;
      end else if (v < lo) begin
         r = 16'sh8000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/sbg_ctrl.sv
// Controller state machine: load, dot product, then one pass emitting results.
module sbg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_in,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sbg_pkg::sbg_sts_type sts,
   output sbg_pkg::sbg_cmd_type cmd
);
   import sbg_pkg::*;

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_SETTLE = 3'd1;
   localparam logic [2:0] ST_DOT    = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_SEND   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_SEND);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last_in) begin
                  state_in = ST_SETTLE;
               end
            end
         end
         ST_SETTLE: begin
            state_in = ST_DOT;
         end
         ST_DOT: begin
            cmd.dot_load = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (sts.last_elem) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/sbg_dpath.sv
// Datapath: element stores, dot product accumulator and result multiplier.
module sbg_dpath #(
   parameter int MAX_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sbg_pkg::sbg_cmd_type              cmd,
   output sbg_pkg::sbg_sts_type              sts,
   input  logic [sbg_pkg::DATA_W-1:0]        req_soft_value,
   input  logic signed [sbg_pkg::DATA_W-1:0] req_upstream_grad,
   output logic signed [sbg_pkg::DATA_W-1:0] rsp_grad_out,
   output logic                              rsp_last_out,
   output logic                              rsp_dropped
);
   import sbg_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [DATA_W-1:0]        soft_mem [MAX_LEN];
   logic [DATA_W-1:0]        grad_mem [MAX_LEN];

   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         rd_ff, rd_in;
   logic                     overflow_ff, overflow_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     term_vld_ff, term_vld_in;
   logic signed [TERM_W-1:0] term_ff;
   logic signed [DATA_W-1:0] dot_ff;
   logic [DATA_W-1:0]        y_rd_ff;
   logic [DATA_W-1:0]        g_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     last_ff;

   logic                     not_full;
   logic                     wr_en;
   logic signed [ACC_W-1:0]  acc_sh;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [DATA_W:0]   diff;

   assign not_full = (fill_ff != CNT_W'(MAX_LEN));
   assign wr_en    = cmd.store && not_full;
   assign acc_sh   = acc_ff >>> FRAC_W;
   assign prod_sh  = prod_ff >>> FRAC_W;
   assign diff     = {g_rd_ff[DATA_W-1], g_rd_ff} - {dot_ff[DATA_W-1], dot_ff};

   always_comb begin
      fill_in     = fill_ff;
      overflow_in = overflow_ff;
      acc_in      = acc_ff;
      rd_in       = rd_ff;
      term_vld_in = wr_en;
      if (cmd.clear) begin
         fill_in     = '0;
         overflow_in = 1'b0;
         acc_in      = '0;
      end else begin
         if (wr_en) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         if (cmd.store && !not_full) begin
            overflow_in = 1'b1;
         end
         if (term_vld_ff) begin
            acc_in = acc_ff + ACC_W'(term_ff);
         end
      end
      if (cmd.dot_load) begin
         rd_in = '0;
      end else if (cmd.advance) begin
         rd_in = rd_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         rd_ff       <= '0;
         overflow_ff <= 1'b0;
         acc_ff      <= '0;
         term_vld_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         rd_ff       <= rd_in;
         overflow_ff <= overflow_in;
         acc_ff      <= acc_in;
         term_vld_ff <= term_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         soft_mem[fill_ff[IDX_W-1:0]] <= req_soft_value;
         grad_mem[fill_ff[IDX_W-1:0]] <= req_upstream_grad;
      end
      if (cmd.rd) begin
         y_rd_ff <= soft_mem[rd_ff[IDX_W-1:0]];
         g_rd_ff <= grad_mem[rd_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= $signed({1'b0, req_soft_value}) * req_upstream_grad;
      if (cmd.dot_load) begin
         dot_ff <= sat16(acc_sh);
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, y_rd_ff}) * diff;
         last_ff <= ((rd_ff + CNT_W'(1)) == fill_ff);
      end
   end

   assign sts.last_elem = last_ff;
   assign rsp_grad_out  = sat16(ACC_W'(prod_sh));
   assign rsp_last_out  = last_ff;
   assign rsp_dropped   = overflow_ff;

endmodule

### hw/rtl/softmax_backward_gradient.sv
// Top level of the softmax backward gradient block.
//
//   channel | words                                   | handshake
//   req     | soft_value, upstream_grad, last_in      | req_valid / req_stall
//   rsp     | grad_out, last_out, dropped             | rsp_valid / rsp_stall
//
// Loading takes one word per cycle while req_stall is low. After the last
// word, the settle and dot states form the dot product, then each result goes
// through store read, multiply and send; send waits while rsp_stall is high.
// No input word is taken while results are being sent.
// Synchronous active-high reset empties the vector; store contents are kept.
module softmax_backward_gradient #(
   parameter int MAX_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sbg_pkg::DATA_W-1:0]        req_soft_value,
   input  logic signed [sbg_pkg::DATA_W-1:0] req_upstream_grad,
   input  logic                              req_last_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [sbg_pkg::DATA_W-1:0] rsp_grad_out,
   output logic                              rsp_last_out,
   output logic                              rsp_dropped
);
   import sbg_pkg::*;

   sbg_cmd_type cmd;
   sbg_sts_type sts;

   sbg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last_in (req_last_in),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   sbg_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_soft_value    (req_soft_value),
      .req_upstream_grad (req_upstream_grad),
      .rsp_grad_out      (rsp_grad_out),
      .rsp_last_out      (rsp_last_out),
      .rsp_dropped       (rsp_dropped)
   );

endmodule

### hw/rtl/sbg_checker.sv
// Port-level checker for the softmax backward gradient block, bound to the top level.
module sbg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_last_in,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [sbg_pkg::DATA_W-1:0] rsp_grad_out,
   input logic                              rsp_last_out,
   input logic                              rsp_dropped
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_grad_out)
         && $stable(rsp_last_out) && $stable(rsp_dropped))
      else $error("stalled result word changed");

   a_no_load_while_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while results are sent");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_out |=> !rsp_valid && !req_stall)
      else $error("vector not closed after final result");

   a_last_in_stops: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_in |=> req_stall && !rsp_valid)
      else $error("input not closed after final element");

endmodule

bind softmax_backward_gradient sbg_checker u_sbg_checker (.*);
